[src/password_lock_controller_core_assert.svh]
// Assertion macros used by the lock controller checker.
`ifndef PASSWORD_LOCK_CONTROLLER_CORE_ASSERT_SVH
`define PASSWORD_LOCK_CONTROLLER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PLC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("lock controller assertion failed");

// Next-cycle implication, checked outside reset.
`define PLC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("lock controller assertion failed");

`endif

[src/plc_pkg.sv]
// Types and constants of the password lock controller.
`timescale 1ns / 1ps
`default_nettype none

package plc_pkg;

	localparam int DigitW = 8;
	localparam int TickW  = 16;
	localparam int FailW  = 4;
	localparam int DutyW  = 7;
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 16;

	localparam logic [DutyW-1:0] MaxSpeed = 7'd100;

	// Operation codes
	localparam logic [1:0] OP_TICK   = 2'd0;
	localparam logic [1:0] OP_SAVE   = 2'd1;
	localparam logic [1:0] OP_OPEN   = 2'd2;
	localparam logic [1:0] OP_CHANGE = 2'd3;

	// Reply codes
	localparam logic [2:0] RPL_NONE    = 3'd0;
	localparam logic [2:0] RPL_CORRECT = 3'd1;
	localparam logic [2:0] RPL_WRONG   = 3'd2;
	localparam logic [2:0] RPL_LOCKED  = 3'd3;
	localparam logic [2:0] RPL_GRANTED = 3'd4;

	// Motor direction codes
	localparam logic [1:0] DIR_OFF = 2'd0;
	localparam logic [1:0] DIR_CW  = 2'd1;
	localparam logic [1:0] DIR_CCW = 2'd2;

	// Register indexes
	localparam logic [CfgIdxW-1:0] REG_ROTATE = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_HOLD   = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_ALARM  = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_MAXFAIL = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_DUTY   = 3'd4;

	// Register reset values
	localparam logic [TickW-1:0] RST_ROTATE  = 16'd55;
	localparam logic [TickW-1:0] RST_HOLD    = 16'd15;
	localparam logic [TickW-1:0] RST_ALARM   = 16'd250;
	localparam logic [FailW-1:0] RST_MAXFAIL = 4'd3;
	localparam logic [DutyW-1:0] RST_DUTY    = 7'd50;

	typedef struct packed {
		logic [1:0]        operation;
		logic [DigitW-1:0] digit_a;
		logic [DigitW-1:0] digit_b;
		logic [DigitW-1:0] digit_c;
		logic [DigitW-1:0] digit_d;
	} req_t;

	typedef struct packed {
		logic [2:0]       reply;
		logic [1:0]       motor_dir;
		logic [DutyW-1:0] motor_speed;
		logic             buzzer;
		logic             busy_res;
	} rsp_t;

	typedef struct packed {
		logic [TickW-1:0] rotate_ticks;
		logic [TickW-1:0] hold_ticks;
		logic [TickW-1:0] alarm_ticks;
		logic [FailW-1:0] max_failures;
		logic [DutyW-1:0] motor_duty;
	} cfg_t;

endpackage

`default_nettype wire

[src/plc_cfg.sv]
// Configuration register file of the lock controller.
`timescale 1ns / 1ps
`default_nettype none

module plc_cfg (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          wr_en,
	input  wire logic [plc_pkg::CfgIdxW-1:0]   wr_index,
	input  wire logic [plc_pkg::CfgDataW-1:0]  wr_data,
	output plc_pkg::cfg_t                      cfg
);

	plc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rotate_ticks <= plc_pkg::RST_ROTATE;
			cfg_q.hold_ticks   <= plc_pkg::RST_HOLD;
			cfg_q.alarm_ticks  <= plc_pkg::RST_ALARM;
			cfg_q.max_failures <= plc_pkg::RST_MAXFAIL;
			cfg_q.motor_duty   <= plc_pkg::RST_DUTY;
		end else if (wr_en) begin
			unique case (wr_index)
				plc_pkg::REG_ROTATE:  cfg_q.rotate_ticks <= wr_data;
				plc_pkg::REG_HOLD:    cfg_q.hold_ticks   <= wr_data;
				plc_pkg::REG_ALARM:   cfg_q.alarm_ticks  <= wr_data;
				plc_pkg::REG_MAXFAIL: cfg_q.max_failures <= wr_data[plc_pkg::FailW-1:0];
				plc_pkg::REG_DUTY:    cfg_q.motor_duty   <= wr_data[plc_pkg::DutyW-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[src/plc_fsm.sv]
// Lock state machine: code store, failure count, door and alarm phases.
`timescale 1ns / 1ps
`default_nettype none

module plc_fsm (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire plc_pkg::cfg_t cfg,
	input  wire logic          fire,
	input  wire plc_pkg::req_t item,
	output plc_pkg::rsp_t      result
);

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_CW    = 3'd1,
		PH_HOLD  = 3'd2,
		PH_CCW   = 3'd3,
		PH_ALARM = 3'd4
	} phase_t;

	phase_t                             phase_q, phase_n;
	logic [plc_pkg::TickW-1:0]          tick_q, tick_n, tick_inc, phase_len;
	logic [plc_pkg::FailW-1:0]          fail_q, fail_n, fail_inc;
	logic [3:0][plc_pkg::DigitW-1:0]    code_q, code_n, digits;
	logic [2:0]                         reply_n;
	logic                               match;
	plc_pkg::rsp_t                      rsp_n, rsp_q;

	assign digits   = {item.digit_a, item.digit_b, item.digit_c, item.digit_d};
	assign match    = (digits == code_q);
	assign tick_inc = tick_q + plc_pkg::TickW'(1);
	assign fail_inc = fail_q + plc_pkg::FailW'(1);

	always_comb begin
		unique case (phase_q)
			PH_HOLD:  phase_len = cfg.hold_ticks;
			PH_ALARM: phase_len = cfg.alarm_ticks;
			default:  phase_len = cfg.rotate_ticks;
		endcase
	end

	always_comb begin
		phase_n = phase_q;
		tick_n  = tick_q;
		fail_n  = fail_q;
		code_n  = code_q;
		reply_n = plc_pkg::RPL_NONE;
		if (phase_q != PH_IDLE || item.operation == plc_pkg::OP_TICK) begin
			// advance the running phase; a request while busy counts as a tick
			if (phase_q != PH_IDLE) begin
				tick_n = tick_inc;
				if (tick_inc >= phase_len) begin
					tick_n = '0;
					unique case (phase_q)
						PH_CW:   phase_n = PH_HOLD;
						PH_HOLD: phase_n = PH_CCW;
						default: phase_n = PH_IDLE;
					endcase
				end
			end
		end else if (item.operation == plc_pkg::OP_SAVE) begin
			code_n = digits;
		end else if (match) begin
			if (item.operation == plc_pkg::OP_OPEN) begin
				fail_n  = '0;
				reply_n = plc_pkg::RPL_CORRECT;
				phase_n = PH_CW;
				tick_n  = '0;
			end else begin
				reply_n = plc_pkg::RPL_GRANTED;
			end
		end else if (fail_inc >= cfg.max_failures) begin
			fail_n  = '0;
			reply_n = plc_pkg::RPL_LOCKED;
			phase_n = PH_ALARM;
			tick_n  = '0;
		end else begin
			fail_n  = fail_inc;
			reply_n = plc_pkg::RPL_WRONG;
		end
	end

	always_comb begin
		rsp_n.reply       = reply_n;
		rsp_n.motor_dir   = plc_pkg::DIR_OFF;
		rsp_n.motor_speed = '0;
		if (phase_n == PH_CW || phase_n == PH_CCW) begin
			rsp_n.motor_dir   = (phase_n == PH_CW) ? plc_pkg::DIR_CW : plc_pkg::DIR_CCW;
			rsp_n.motor_speed = (cfg.motor_duty > plc_pkg::MaxSpeed) ? plc_pkg::MaxSpeed
				: cfg.motor_duty;
		end
		rsp_n.buzzer   = (phase_n == PH_ALARM);
		rsp_n.busy_res = (phase_n != PH_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q  <= '0;
			fail_q  <= '0;
			code_q  <= '0;
		end else if (fire) begin
			phase_q <= phase_n;
			tick_q  <= tick_n;
			fail_q  <= fail_n;
			code_q  <= code_n;
		end
	end

	// result register: payload only, valid lives in the top level
	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_q <= rsp_n;
		end
	end

	assign result = rsp_q;

endmodule

`default_nettype wire

[src/password_lock_controller_core.sv]
// Top level of the password lock controller.
// One request or timer tick is taken per item and every item yields exactly one result
// showing the reply and the motor, buzzer and busy state after it. The block sustains
// one item per clock while the output side takes its results: an input register holds
// the accepted item, and the state machine updates the code store, failure count and
// phase counter in one pass and loads the result register, from which the result is
// taken. The result register frees whenever its item is taken or moves on, which keeps
// req_ready high while the output side drains; with both registers full and the output
// stalled, req_ready drops. Requests that arrive during the door sequence or the alarm
// only advance the phase counter and reply none. Configuration writes are taken in
// every cycle (cfg_ready is always high); indexes beyond the five registers are dropped.
`timescale 1ns / 1ps
`default_nettype none

module password_lock_controller_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         req_valid,
	output logic                              req_ready,
	input  wire plc_pkg::req_t                req,
	output logic                              rsp_valid,
	input  wire logic                         rsp_ready,
	output plc_pkg::rsp_t                     rsp,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [plc_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [plc_pkg::CfgDataW-1:0] cfg_data
);

	plc_pkg::cfg_t cfg;
	plc_pkg::req_t item_s1;
	logic          valid_s1;
	logic          fire;
	logic          rsp_valid_q;

	// register file: always ready
	assign cfg_ready = 1'b1;

	plc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// advance the held item when the result register is empty or being drained
	assign fire      = valid_s1 & (~rsp_valid_q | rsp_ready);
	assign req_ready = ~valid_s1 | fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	// hold the item payload until it moves into the state machine
	always_ff @(posedge clk) begin
		if (req_valid & req_ready) begin
			item_s1 <= req;
		end
	end

	plc_fsm u_fsm (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.fire   (fire),
		.item   (item_s1),
		.result (rsp)
	);

	// result valid: set on each processed item, drop when taken without replacement
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

`default_nettype wire

[src/plc_checker.sv]
// Port-level checker for the lock controller, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "password_lock_controller_core_assert.svh"

module plc_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          rsp_valid,
	input wire logic          rsp_ready,
	input wire plc_pkg::rsp_t rsp
);

	`PLC_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))
	`PLC_ASSERT_IMP(a_idle_quiet, clk, arst_n, rsp_valid && !rsp.busy_res, rsp.motor_dir == plc_pkg::DIR_OFF && !rsp.buzzer && rsp.motor_speed == '0)
	`PLC_ASSERT_IMP(a_alarm_motor_off, clk, arst_n, rsp_valid && rsp.buzzer, rsp.busy_res && rsp.motor_dir == plc_pkg::DIR_OFF && rsp.motor_speed == '0)
	`PLC_ASSERT_IMP(a_correct_starts_cw, clk, arst_n, rsp_valid && rsp.reply == plc_pkg::RPL_CORRECT, rsp.motor_dir == plc_pkg::DIR_CW && !rsp.buzzer)
	`PLC_ASSERT_IMP(a_locked_sounds, clk, arst_n, rsp_valid && rsp.reply == plc_pkg::RPL_LOCKED, rsp.buzzer && rsp.busy_res)

endmodule

bind password_lock_controller_core plc_checker u_plc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp       (rsp)
);

`default_nettype wire
